### src/gcbt_pkg.sv
`default_nettype none

package gcbt_pkg;

    localparam int WORD_W   = 32;
    localparam int REM_W    = 19;
    localparam int POS_W    = 4;
    localparam int TPOS_W   = 3;
    localparam int LEFT_W   = 4;
    localparam int REPORT_W = 20;

    localparam logic [7:0]  CMD_FILL  = 8'h02;
    localparam logic [7:0]  ENV_FIRST = 8'hE1;
    localparam logic [7:0]  ENV_LAST  = 8'hE6;

    localparam logic [31:0] POLY_TERM_MASK  = 32'hF000_F000;
    localparam logic [31:0] POLY_TERM_VALUE = 32'h5000_5000;

    localparam logic [TPOS_W-1:0] TPOS_FLAT   = 3'd4;
    localparam logic [TPOS_W-1:0] TPOS_SHADED = 3'd5;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_FIXED   = 3'd1,
        PH_POLY    = 3'd2,
        PH_UP_HDR  = 3'd3,
        PH_UP_DATA = 3'd4,
        PH_RD_HDR  = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        GRP_MISC  = 3'd0,
        GRP_POLY  = 3'd1,
        GRP_LINE  = 3'd2,
        GRP_RECT  = 3'd3,
        GRP_COPY  = 3'd4,
        GRP_UPLD  = 3'd5,
        GRP_READ  = 3'd6,
        GRP_ENV   = 3'd7
    } cmd_group_t;

    typedef struct packed {
        logic                starts_command;
        logic [7:0]          environment_code;
        logic                texpage_update;
        logic [8:0]          texpage_bits;
        logic [9:0]          texture_x_base;
        logic [8:0]          texture_y_base;
        logic [1:0]          texture_depth;
        logic [REPORT_W-1:0] reads_outstanding;
        logic                read_accepted;
        phase_t              phase_after;
    } result_t;

endpackage

`default_nettype wire

### src/gcbt_parser.sv
`default_nettype none

module gcbt_parser
    import gcbt_pkg::*;
#(
    parameter int OWED_WIDTH = 20
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step_en,
    input  wire logic              mode,
    input  wire logic [WORD_W-1:0] word,
    output result_t                result
);

    phase_t                  phase_reg, phase_next;
    logic [REM_W-1:0]        rem_reg, rem_next;
    logic [POS_W-1:0]        pos_reg, pos_next;
    logic [TPOS_W-1:0]       tpos_reg, tpos_next;
    logic [OWED_WIDTH-1:0]   owed_reg, owed_next;

    // idle decode
    logic [7:0]              cmd;
    cmd_group_t              grp;
    logic [LEFT_W-1:0]       idle_left;
    phase_t                  idle_phase;
    logic [TPOS_W-1:0]       idle_tpos;
    logic [7:0]              idle_env;
    logic [2:0]              verts;
    logic [1:0]              mult;
    logic [4:0]              poly_len;

    // size word to data words
    logic [10:0]             xs;
    logic [9:0]              ys;
    logic [20:0]             area;
    logic [20:0]             area_inc;
    logic [REM_W-1:0]        size_words;

    logic [REM_W-1:0]        rem_dec;
    logic [POS_W-1:0]        pos_inc;
    logic [OWED_WIDTH:0]     owed_sum;
    logic [OWED_WIDTH-1:0]   owed_sat;
    logic [OWED_WIDTH+REPORT_W-1:0] owed_ext;
    logic                    term_hit;
    logic                    tex_hit;
    logic [15:0]             page;

    assign cmd = word[31:24];
    assign grp = cmd_group_t'(cmd[7:5]);

    assign xs       = {1'b0, word[9:0] - 10'd1} + 11'd1;
    assign ys       = {1'b0, word[24:16] - 9'd1} + 10'd1;
    assign area     = 21'(xs) * 21'(ys);
    assign area_inc = area + 21'd1;
    assign size_words = area_inc[REM_W:1];

    assign rem_dec  = rem_reg - {{(REM_W-1){1'b0}}, 1'b1};
    assign pos_inc  = pos_reg + {{(POS_W-1){1'b0}}, 1'b1};
    assign owed_sum = {1'b0, owed_reg} + {{(OWED_WIDTH+1-REM_W){1'b0}}, size_words};
    assign owed_sat = owed_sum[OWED_WIDTH] ? {OWED_WIDTH{1'b1}} : owed_sum[OWED_WIDTH-1:0];
    assign owed_ext = {{REPORT_W{1'b0}}, owed_next};
    assign term_hit = (word & POLY_TERM_MASK) == POLY_TERM_VALUE;
    assign tex_hit  = (tpos_reg != '0) && (pos_inc == {1'b0, tpos_reg});
    assign page     = word[31:16];

    assign verts    = cmd[3] ? 3'd4 : 3'd3;
    assign mult     = 2'd1 + {1'b0, cmd[2]} + {1'b0, cmd[4]};
    assign poly_len = 5'(verts) * 5'(mult) + {4'b0, ~cmd[4]} - 5'd1;

    always_comb
    begin
        idle_left  = '0;
        idle_phase = PH_IDLE;
        idle_tpos  = '0;
        idle_env   = '0;
        unique case (grp)
            GRP_MISC:
            begin
                idle_left = (cmd == CMD_FILL) ? LEFT_W'(2) : '0;
            end
            GRP_POLY:
            begin
                idle_left = poly_len[LEFT_W-1:0];
                if (cmd[2])
                begin
                    idle_tpos = cmd[4] ? TPOS_SHADED : TPOS_FLAT;
                end
            end
            GRP_LINE:
            begin
                if (cmd[3])
                begin
                    idle_phase = PH_POLY;
                end
                else
                begin
                    idle_left = cmd[4] ? LEFT_W'(3) : LEFT_W'(2);
                end
            end
            GRP_RECT:
            begin
                idle_left = LEFT_W'(1) + LEFT_W'(cmd[2]) + LEFT_W'(cmd[4:3] == 2'b00);
            end
            GRP_COPY:
            begin
                idle_left = LEFT_W'(3);
            end
            GRP_UPLD:
            begin
                idle_phase = PH_UP_HDR;
                idle_left  = LEFT_W'(2);
            end
            GRP_READ:
            begin
                idle_phase = PH_RD_HDR;
                idle_left  = LEFT_W'(2);
            end
            GRP_ENV:
            begin
                if (cmd >= ENV_FIRST && cmd <= ENV_LAST)
                begin
                    idle_env = cmd;
                end
            end
            default:
            begin
                idle_left = '0;
            end
        endcase
        if (idle_phase == PH_IDLE && idle_left != '0)
        begin
            idle_phase = PH_FIXED;
        end
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        rem_next   = rem_reg;
        pos_next   = pos_reg;
        tpos_next  = tpos_reg;
        owed_next  = owed_reg;
        if (mode)
        begin
            if (owed_reg != '0)
            begin
                owed_next = owed_reg - {{(OWED_WIDTH-1){1'b0}}, 1'b1};
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    pos_next   = '0;
                    tpos_next  = idle_tpos;
                    rem_next   = REM_W'(idle_left);
                    phase_next = idle_phase;
                end
                PH_FIXED:
                begin
                    pos_next = pos_inc;
                    rem_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_POLY:
                begin
                    if (term_hit)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_UP_HDR:
                begin
                    rem_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        rem_next   = size_words;
                        phase_next = (size_words != '0) ? PH_UP_DATA : PH_IDLE;
                    end
                end
                PH_UP_DATA:
                begin
                    rem_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                PH_RD_HDR:
                begin
                    rem_next = rem_dec;
                    if (rem_dec == '0)
                    begin
                        owed_next  = owed_sat;
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // result fields
    always_comb
    begin
        result                   = '0;
        result.reads_outstanding = owed_ext[REPORT_W-1:0];
        result.phase_after       = phase_next;
        if (mode)
        begin
            result.read_accepted = (owed_reg != '0);
        end
        else if (phase_reg == PH_IDLE)
        begin
            result.starts_command   = 1'b1;
            result.environment_code = idle_env;
        end
        else if (phase_reg == PH_FIXED && tex_hit)
        begin
            result.texpage_update = 1'b1;
            result.texpage_bits   = page[8:0];
            result.texture_x_base = {page[3:0], 6'b0};
            result.texture_y_base = {page[4], 8'b0};
            result.texture_depth  = page[8:7];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            rem_reg   <= '0;
            pos_reg   <= '0;
            tpos_reg  <= '0;
            owed_reg  <= '0;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            rem_reg   <= rem_next;
            pos_reg   <= pos_next;
            tpos_reg  <= tpos_next;
            owed_reg  <= owed_next;
        end
    end

endmodule

`default_nettype wire

### src/gp0_command_boundary_tracker.sv
// GP0 command boundary tracker. Takes one transaction per clock while in_stall
// is low (a GP0 word, or a VRAM-to-CPU read word when mode is 1) and returns
// one result per transaction: each is held in the input register, then the
// parser step (opcode decode, an 11x10 size multiply and the saturating add
// to the owed-read count) writes the result register. Sustained rate is one
// transaction per cycle while out_stall stays low; in_stall follows out_stall
// only when both the input and result registers are full.
// No clearing pass after reset.
`default_nettype none

module gp0_command_boundary_tracker
    import gcbt_pkg::*;
#(
    parameter int OWED_WIDTH = 20
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_stall,
    input  wire logic                mode,
    input  wire logic [WORD_W-1:0]   word,
    output logic                     out_valid,
    input  wire logic                out_stall,
    output logic                     starts_command,
    output logic [7:0]               environment_code,
    output logic                     texpage_update,
    output logic [8:0]               texpage_bits,
    output logic [9:0]               texture_x_base,
    output logic [8:0]               texture_y_base,
    output logic [1:0]               texture_depth,
    output logic [REPORT_W-1:0]      reads_outstanding,
    output logic                     read_accepted,
    output logic [2:0]               phase_after
);

    logic              s1_valid_reg;
    logic              s1_mode_reg;
    logic [WORD_W-1:0] s1_word_reg;
    logic              out_valid_reg;
    result_t           out_reg;
    result_t           step_result;
    logic              s1_adv;
    logic              in_take;
    logic              step_en;

    assign s1_adv   = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !s1_adv;
    assign in_take  = in_valid && !in_stall;
    assign step_en  = s1_valid_reg && s1_adv;

    gcbt_parser #(
        .OWED_WIDTH (OWED_WIDTH)
    ) u_parser (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .mode    (s1_mode_reg),
        .word    (s1_word_reg),
        .result  (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (!in_stall)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_adv)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_mode_reg <= mode;
            s1_word_reg <= word;
        end
        if (step_en)
        begin
            out_reg <= step_result;
        end
    end

    assign out_valid         = out_valid_reg;
    assign starts_command    = out_reg.starts_command;
    assign environment_code  = out_reg.environment_code;
    assign texpage_update    = out_reg.texpage_update;
    assign texpage_bits      = out_reg.texpage_bits;
    assign texture_x_base    = out_reg.texture_x_base;
    assign texture_y_base    = out_reg.texture_y_base;
    assign texture_depth     = out_reg.texture_depth;
    assign reads_outstanding = out_reg.reads_outstanding;
    assign read_accepted     = out_reg.read_accepted;
    assign phase_after       = out_reg.phase_after;

endmodule

`default_nettype wire
